// ===== sv/chunked_message_deframer_unit_macros.svh =====
// Assertion macros used by the parser RTL file.
`ifndef CHUNKED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH
`define CHUNKED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CMD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CMD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CMD_ASSERT(name, prop, msg)
`define CMD_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== sv/cmd_pkg.sv =====
package cmd_pkg;

  localparam logic [15:0] ChunkLimitReset = 16'd16383;
  localparam logic [23:0] MsgLimitReset   = 24'd1048576;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_END       = 2'd1,
    KIND_CHUNK_BIG = 2'd2,
    KIND_MSG_BIG   = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    REG_MAX_CHUNK = 1'b0,
    REG_MAX_MSG   = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_HDR_HI  = 4'b0001,
    PH_HDR_LO  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CLOSED  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [15:0] max_chunk;
    logic [23:0] max_msg;
  } limits_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
  } res_t;

endpackage

// ===== sv/cmd_cfg_regs.sv =====
module cmd_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [23:0]      cfg_wdata_i,
  output cmd_pkg::limits_t limits_o
);
  import cmd_pkg::*;

  limits_t limits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.max_chunk <= ChunkLimitReset;
      limits_q.max_msg   <= MsgLimitReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MAX_CHUNK: limits_q.max_chunk <= cfg_wdata_i[15:0];
        REG_MAX_MSG:   limits_q.max_msg   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign limits_o = limits_q;

endmodule

// ===== sv/cmd_in_stage.sv =====
module cmd_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           out_ready_i,
  output cmd_pkg::step_t step_o
);
  import cmd_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       step_en;
  logic       accept;

  assign step_en    = valid_q && out_ready_i;
  assign in_stall_o = valid_q && !step_en;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (step_en) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign step_o.en   = step_en;
  assign step_o.data = byte_q;

endmodule

// ===== sv/cmd_parser.sv =====
module cmd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_pkg::step_t   step_i,
  input  cmd_pkg::limits_t limits_i,
  output cmd_pkg::res_t    res_o
);
  import cmd_pkg::*;
  `include "chunked_message_deframer_unit_macros.svh"

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_hi_q, hdr_hi_d;
  logic [15:0] rem_q, rem_d;
  logic [23:0] msg_len_q, msg_len_d;
  logic [15:0] size;
  logic [24:0] sum;
  res_t        res;

  assign size = {hdr_hi_q, step_i.data};
  assign sum  = {1'b0, msg_len_q} + {9'd0, size};

  always_comb begin
    phase_d   = phase_q;
    hdr_hi_d  = hdr_hi_q;
    rem_d     = rem_q;
    msg_len_d = msg_len_q;
    res.valid = 1'b0;
    res.kind  = KIND_DATA;
    res.data  = 8'd0;
    if (step_i.en) begin
      unique case (phase_q)
        PH_HDR_HI: begin
          hdr_hi_d = step_i.data;
          phase_d  = PH_HDR_LO;
        end
        PH_HDR_LO: begin
          if (size == 16'd0) begin
            phase_d = PH_HDR_HI;
            if (msg_len_q != 24'd0) begin
              msg_len_d = 24'd0;
              res.valid = 1'b1;
              res.kind  = KIND_END;
            end
          end else if (size > limits_i.max_chunk) begin
            phase_d   = PH_CLOSED;
            rem_d     = 16'd0;
            msg_len_d = 24'd0;
            res.valid = 1'b1;
            res.kind  = KIND_CHUNK_BIG;
          end else if (sum > {1'b0, limits_i.max_msg}) begin
            phase_d   = PH_CLOSED;
            rem_d     = 16'd0;
            msg_len_d = 24'd0;
            res.valid = 1'b1;
            res.kind  = KIND_MSG_BIG;
          end else begin
            msg_len_d = sum[23:0];
            rem_d     = size;
            phase_d   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          rem_d     = rem_q - 16'd1;
          res.valid = 1'b1;
          res.kind  = KIND_DATA;
          res.data  = step_i.data;
          if (rem_q == 16'd1) begin
            phase_d = PH_HDR_HI;
          end
        end
        PH_CLOSED: ;
        default: phase_d = PH_CLOSED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR_HI;
      hdr_hi_q  <= 8'd0;
      rem_q     <= 16'd0;
      msg_len_q <= 24'd0;
    end else begin
      phase_q   <= phase_d;
      hdr_hi_q  <= hdr_hi_d;
      rem_q     <= rem_d;
      msg_len_q <= msg_len_d;
    end
  end

  assign res_o = res;

  `CMD_ASSERT(a_closed_sticks, phase_q == PH_CLOSED |=> phase_q == PH_CLOSED,
              "closed parser reopened")
  `CMD_ASSERT(a_error_closes,
              step_i.en && res.valid && (res.kind == KIND_CHUNK_BIG ||
              res.kind == KIND_MSG_BIG) |=> phase_q == PH_CLOSED && msg_len_q == 24'd0,
              "error did not close the parser")
  `CMD_ASSERT(a_payload_count, phase_q == PH_PAYLOAD |-> rem_q != 16'd0,
              "payload phase with no bytes due")
  `CMD_ASSERT(a_idle_no_result, !step_i.en |-> !res.valid,
              "result without an item")

endmodule

// ===== sv/cmd_out_stage.sv =====
module cmd_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  cmd_pkg::res_t res_i,
  output logic          out_ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    out_kind_o,
  output logic [7:0]    out_byte_o
);
  import cmd_pkg::*;

  logic       valid_q;
  kind_e      kind_q;
  logic [7:0] byte_q;

  assign out_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step_en_i) begin
      valid_q <= res_i.valid;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en_i && res_i.valid) begin
      kind_q <= res_i.kind;
      byte_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;

endmodule

// ===== sv/chunked_message_deframer_unit.sv =====
// Chunked message deframer: takes one stream byte per item and parses two-byte
// big-endian chunk headers, each followed by that many payload bytes, with a zero
// header closing a message. It yields at most one result per item: a payload byte,
// an end of message, or a chunk or message limit error, after which it stays closed
// until reset. It accepts one item per cycle, sustained while the output is not
// stalled; a result is offered from the result register after its item has passed
// the input register and the combinational header and limit check. Limits may be
// rewritten between messages and apply from the next header on.
module chunked_message_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o
);
  import cmd_pkg::*;

  limits_t limits;
  step_t   step;
  res_t    res;
  logic    out_ready;

  cmd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .limits_o    (limits)
  );

  cmd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_ready_i (out_ready),
    .step_o      (step)
  );

  cmd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .limits_i (limits),
    .res_o    (res)
  );

  cmd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step.en),
    .res_i       (res),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o)
  );

endmodule
